// File: src/cds_pkg.sv
// shared types, constants and calendar helpers for the date stepper
`timescale 1ns / 1ps
`default_nettype none

package cds_pkg;

  localparam logic [13:0] MAX_YEAR      = 14'd9999;
  localparam logic [13:0] RESET_YEAR    = 14'd1900;
  localparam logic [13:0] WD_FIRST_YEAR = 14'd2001;
  localparam logic [13:0] WD_LAST_YEAR  = 14'd2099;

  // floor(y / 100) = (y * 5243) >> 19 for every 14-bit y
  localparam logic [26:0] DIV100_RECIP  = 27'd5243;
  // floor(v / 7) = (v * 147) >> 10 for v up to 159
  localparam logic [15:0] DIV7_RECIP    = 16'd147;

  localparam logic [1:0] CMD_SET = 2'd0;
  localparam logic [1:0] CMD_ADD = 2'd1;
  localparam logic [1:0] CMD_SUB = 2'd2;

  localparam logic [1:0] STS_OK     = 2'd0;
  localparam logic [1:0] STS_REJECT = 2'd1;
  localparam logic [1:0] STS_LIMIT  = 2'd2;

  typedef struct packed {
    logic [1:0]  command;
    logic [15:0] day_count;
    logic [13:0] new_year;
    logic [3:0]  new_month;
    logic [4:0]  new_day;
  } item_t;

  typedef struct packed {
    logic [13:0] cur_year;
    logic [3:0]  cur_month;
    logic [4:0]  cur_day;
    logic [2:0]  weekday;
    logic [1:0]  status;
  } result_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LEAP1,
    ST_LEAP2,
    ST_EXEC,
    ST_FINISH
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic set_exec;
    logic step;
    logic flag_limit;
    logic finish;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_set;
    logic is_step;
    logic count_zero;
    logic at_limit;
    logic out_busy;
  } dp_status_t;

  function automatic logic [4:0] days_in(input logic [3:0] month, input logic leap);
    logic [4:0] len;
    case (month) inside
      4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
      4'd2:                    len = leap ? 5'd29 : 5'd28;
      default:                 len = 5'd31;
    endcase
    return len;
  endfunction

  function automatic logic [2:0] month_code(input logic [3:0] month);
    logic [2:0] code;
    unique case (month)
      4'd1:    code = 3'd0;
      4'd2:    code = 3'd3;
      4'd3:    code = 3'd3;
      4'd4:    code = 3'd6;
      4'd5:    code = 3'd1;
      4'd6:    code = 3'd4;
      4'd7:    code = 3'd6;
      4'd8:    code = 3'd2;
      4'd9:    code = 3'd5;
      4'd10:   code = 3'd0;
      4'd11:   code = 3'd3;
      4'd12:   code = 3'd5;
      default: code = 3'd0;
    endcase
    return code;
  endfunction

endpackage

`default_nettype wire

// File: src/cds_leap.sv
// two-stage leap year unit, divides by 100 through a reciprocal multiply
`timescale 1ns / 1ps
`default_nettype none

module cds_leap (
  input  wire logic        clk,
  input  wire logic [13:0] year,
  output logic             leap
);

  logic [26:0] prod;
  logic [7:0]  quot;
  logic [13:0] year_d;
  logic [13:0] hundreds;
  logic        div100;

  assign prod = 27'(year) * cds_pkg::DIV100_RECIP;

  always_ff @(posedge clk) begin
    quot   <= prod[26:19];
    year_d <= year;
  end

  // quot * 100 as shifts and adds
  assign hundreds = {quot, 6'b0} + {1'b0, quot, 5'b0} + {4'b0, quot, 2'b0};
  assign div100   = (hundreds == year_d);

  always_ff @(posedge clk) begin
    leap <= div100 ? (quot[1:0] == 2'b00) : (year_d[1:0] == 2'b00);
  end

endmodule

`default_nettype wire

// File: src/cds_datapath.sv
// date registers, day step logic, set check, weekday and result register
`timescale 1ns / 1ps
`default_nettype none

module cds_datapath #(
  parameter int COUNT_BITS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire cds_pkg::item_t     item,
  input  wire logic               cfg_we,
  input  wire logic [13:0]        cfg_data,
  input  wire cds_pkg::ctrl_cmd_t ctrl,
  output cds_pkg::dp_status_t     stat,
  output cds_pkg::result_t        result,
  output logic                    result_valid,
  input  wire logic               result_stall
);

  localparam int CNT_W = (COUNT_BITS < 16) ? COUNT_BITS : 16;

  logic [13:0]      min_year;
  logic [13:0]      lo;
  logic [1:0]       cmd;
  logic [13:0]      in_year;
  logic [3:0]       in_month;
  logic [4:0]       in_day;
  logic [CNT_W-1:0] count;
  logic [13:0]      year;
  logic [3:0]       month;
  logic [4:0]       day;
  logic [1:0]       status;
  logic             leap;
  logic [13:0]      leap_year;
  logic [4:0]       dim;
  logic [4:0]       prev_dim;
  logic [4:0]       in_dim;
  logic             set_ok;
  logic             top_limit;
  logic             bot_limit;
  logic [13:0]      year_next;
  logic [3:0]       month_next;
  logic [4:0]       day_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_year <= cds_pkg::RESET_YEAR;
    end else if (cfg_we) begin
      min_year <= cfg_data;
    end
  end

  assign lo = (min_year == 14'd0) ? 14'd1 :
              (min_year > cds_pkg::MAX_YEAR) ? cds_pkg::MAX_YEAR : min_year;

  // leap flag follows the new year for a set, the held year otherwise
  assign leap_year = (cmd == cds_pkg::CMD_SET) ? in_year : year;

  cds_leap u_leap (
    .clk  (clk),
    .year (leap_year),
    .leap (leap)
  );

  assign dim      = cds_pkg::days_in(month, leap);
  assign prev_dim = cds_pkg::days_in(month - 4'd1, leap);
  assign in_dim   = cds_pkg::days_in(in_month, leap);

  assign set_ok = (in_year >= lo) && (in_year <= cds_pkg::MAX_YEAR) &&
                  (in_month >= 4'd1) && (in_month <= 4'd12) &&
                  (in_day >= 5'd1) && (in_day <= in_dim);

  assign top_limit = (year >= cds_pkg::MAX_YEAR) && (month == 4'd12) && (day >= 5'd31);
  assign bot_limit = (year < lo) ||
                     ((year == lo) && (month <= 4'd1) && (day <= 5'd1));

  // one day forward or back
  always_comb begin
    year_next  = year;
    month_next = month;
    day_next   = day;
    if (cmd == cds_pkg::CMD_ADD) begin
      if (day >= dim) begin
        day_next = 5'd1;
        if (month >= 4'd12) begin
          month_next = 4'd1;
          year_next  = year + 14'd1;
        end else begin
          month_next = month + 4'd1;
        end
      end else begin
        day_next = day + 5'd1;
      end
    end else begin
      if (day <= 5'd1) begin
        if (month <= 4'd1) begin
          month_next = 4'd12;
          year_next  = year - 14'd1;
          day_next   = 5'd31;
        end else begin
          month_next = month - 4'd1;
          day_next   = prev_dim;
        end
      end else begin
        day_next = day - 5'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      cmd      <= item.command;
      in_year  <= item.new_year;
      in_month <= item.new_month;
      in_day   <= item.new_day;
      count    <= item.day_count[CNT_W-1:0];
    end else if (ctrl.step) begin
      count <= count - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      status <= cds_pkg::STS_OK;
    end else if (ctrl.set_exec && !set_ok) begin
      status <= cds_pkg::STS_REJECT;
    end else if (ctrl.flag_limit) begin
      status <= cds_pkg::STS_LIMIT;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      year  <= cds_pkg::RESET_YEAR;
      month <= 4'd1;
      day   <= 5'd1;
    end else if (ctrl.set_exec && set_ok) begin
      year  <= in_year;
      month <= in_month;
      day   <= in_day;
    end else if (ctrl.step) begin
      year  <= year_next;
      month <= month_next;
      day   <= day_next;
    end
  end

  assign stat.is_set     = (cmd == cds_pkg::CMD_SET);
  assign stat.is_step    = (cmd == cds_pkg::CMD_ADD) || (cmd == cds_pkg::CMD_SUB);
  assign stat.count_zero = (count == '0);
  assign stat.at_limit   = (cmd == cds_pkg::CMD_ADD) ? top_limit : bot_limit;
  assign stat.out_busy   = result_valid && result_stall;

  // weekday, table formula over 2001 to 2099
  logic [13:0] wd_diff;
  logic [6:0]  t1;
  logic [3:0]  t2;
  logic [7:0]  wd_sum;
  logic [15:0] wd_prod;
  logic [7:0]  wd_quot;
  logic [7:0]  wd_rem;
  logic [2:0]  weekday;

  assign wd_diff = year - cds_pkg::WD_FIRST_YEAR;
  assign t1      = wd_diff[6:0];
  assign t2      = {1'b0, cds_pkg::month_code(month)} +
                   (((year[1:0] == 2'b00) && (month >= 4'd3)) ? 4'd1 : 4'd0);
  assign wd_sum  = {1'b0, t1} + {3'b0, t1[6:2]} + {4'b0, t2} + {3'b0, day - 5'd1};
  assign wd_prod = 16'(wd_sum) * cds_pkg::DIV7_RECIP;
  assign wd_quot = {2'b0, wd_prod[15:10]};
  assign wd_rem  = wd_sum - ((wd_quot << 3) - wd_quot);
  assign weekday = ((year >= cds_pkg::WD_FIRST_YEAR) && (year <= cds_pkg::WD_LAST_YEAR)) ?
                   (wd_rem[2:0] + 3'd1) : 3'd0;

  always_ff @(posedge clk) begin
    if (ctrl.finish) begin
      result.cur_year  <= year;
      result.cur_month <= month;
      result.cur_day   <= day;
      result.weekday   <= weekday;
      result.status    <= status;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (ctrl.finish) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

endmodule

`default_nettype wire

// File: src/cds_ctrl.sv
// controller state machine for the date stepper
`timescale 1ns / 1ps
`default_nettype none

module cds_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                item_valid,
  output logic                     item_stall,
  input  wire cds_pkg::dp_status_t stat,
  output cds_pkg::ctrl_cmd_t       ctrl
);

  cds_pkg::state_t state;
  cds_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cds_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      cds_pkg::ST_IDLE: begin
        if (item_valid) state_next = cds_pkg::ST_LEAP1;
      end
      cds_pkg::ST_LEAP1: state_next = cds_pkg::ST_LEAP2;
      cds_pkg::ST_LEAP2: state_next = cds_pkg::ST_EXEC;
      cds_pkg::ST_EXEC: begin
        if (!stat.is_step || stat.count_zero || stat.at_limit) begin
          state_next = cds_pkg::ST_FINISH;
        end
      end
      cds_pkg::ST_FINISH: begin
        if (!stat.out_busy) state_next = cds_pkg::ST_IDLE;
      end
      default: state_next = cds_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl       = '0;
    item_stall = 1'b1;
    unique case (state) inside
      cds_pkg::ST_IDLE: begin
        item_stall = 1'b0;
        ctrl.load  = item_valid;
      end
      cds_pkg::ST_LEAP1, cds_pkg::ST_LEAP2: ;
      cds_pkg::ST_EXEC: begin
        ctrl.set_exec = stat.is_set;
        if (stat.is_step && !stat.count_zero) begin
          ctrl.step       = !stat.at_limit;
          ctrl.flag_limit = stat.at_limit;
        end
      end
      cds_pkg::ST_FINISH: ctrl.finish = !stat.out_busy;
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// File: src/calendar_date_stepper_top.sv
// top level of the calendar date stepper: controller, datapath, config port
// sequence: after the transfer, LEAP1 and LEAP2 wait on the leap unit; EXEC then
//   sets the date or steps it one day per cycle until the count or a limit is hit;
//   FINISH writes the result once the output is free; new items wait until idle
// reset: date 1900-01-01, min_year 1900, no result pending
`timescale 1ns / 1ps
`default_nettype none

module calendar_date_stepper_top #(
  parameter int COUNT_BITS = 16
) (
  input  wire logic             clk,
  input  wire logic             rst,
  // item channel
  input  wire logic             item_valid,
  output logic                  item_stall,
  input  wire cds_pkg::item_t   item,
  // result channel
  output logic                  result_valid,
  input  wire logic             result_stall,
  output cds_pkg::result_t      result,
  // min_year write channel
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire logic [13:0]      cfg_data
);

  cds_pkg::ctrl_cmd_t  ctrl;
  cds_pkg::dp_status_t stat;

  // register writes are to come only while idle; the block does not enforce it and always takes them
  assign cfg_ready = 1'b1;

  // state machine: loads an item, waits on the leap unit, sets or steps the date, then
  // hands the result to the output register once it is free
  cds_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .stat       (stat),
    .ctrl       (ctrl)
  );

  // date registers, leap unit, weekday logic and output register; the
  // output register lets the next item start while a result waits
  cds_datapath #(
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .item         (item),
    .cfg_we       (cfg_valid && cfg_ready),
    .cfg_data     (cfg_data),
    .ctrl         (ctrl),
    .stat         (stat),
    .result       (result),
    .result_valid (result_valid),
    .result_stall (result_stall)
  );

endmodule

`default_nettype wire

// File: src/cds_checker.sv
// port level checks for the date stepper and their bind to the top level
`timescale 1ns / 1ps
`default_nettype none

module cds_checker (
  input wire logic             clk,
  input wire logic             rst,
  input wire logic             item_valid,
  input wire logic             item_stall,
  input wire logic             result_valid,
  input wire logic             result_stall,
  input wire cds_pkg::result_t result
);

  // one item at a time: a transfer makes the block busy on the next cycle
  a_busy_after_transfer: assert property (@(posedge clk) disable iff (rst)
    (item_valid && !item_stall) |=> item_stall)
    else $error("item taken while the previous one is still in work");

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_stall) |=> (result_valid && $stable(result)))
    else $error("stalled result changed or dropped");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> ((result.status == cds_pkg::STS_OK) ||
                      (result.status == cds_pkg::STS_REJECT) ||
                      (result.status == cds_pkg::STS_LIMIT)))
    else $error("undefined status code");

  a_date_sane: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> ((result.cur_month >= 4'd1) && (result.cur_month <= 4'd12) &&
                      (result.cur_day >= 5'd1) && (result.cur_year >= 14'd1)))
    else $error("result date out of range");

  a_weekday_range: assert property (@(posedge clk) disable iff (rst)
    (result_valid && ((result.cur_year < cds_pkg::WD_FIRST_YEAR) ||
                      (result.cur_year > cds_pkg::WD_LAST_YEAR)))
      |-> (result.weekday == 3'd0))
    else $error("weekday given outside its year window");

endmodule

bind calendar_date_stepper_top cds_checker u_cds_checker (.*);

`default_nettype wire
